// File: rtl/core/edsa_pkg.sv
// ----------------------------------------------------------------------------
// edsa_pkg
// shared types and constants of the echo doppler snr analyzer
// ----------------------------------------------------------------------------
package edsa_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned NoiseW  = 31;
    localparam int unsigned SpeedW  = 24;
    localparam int unsigned SnrW    = 16;
    localparam int unsigned LenW    = 17;
    localparam int unsigned EnergyW = 48;
    localparam int unsigned SumW    = 40;
    localparam int unsigned GainW   = 24;
    localparam int unsigned RatioW  = 16;
    localparam int unsigned AngleW  = 32;
    localparam int unsigned CordicN = 16;
    localparam int unsigned ProdW   = 34;
    localparam int unsigned LogW    = 16;

    // sample count saturation point, sized to the count field
    localparam int unsigned MaxEchoLen = 65536;

    localparam logic [1:0] RegGain  = 2'd0;
    localparam logic [1:0] RegRatio = 2'd1;

    localparam logic [GainW-1:0]  GainReset  = 24'd167680;
    localparam logic [RatioW-1:0] RatioReset = 16'd256;

    typedef struct packed {
        logic [AngleW-1:0] turn;
    } cordic_entry_t;

    function automatic logic [AngleW-1:0] cordic_turn(input logic [3:0] i);
        logic [AngleW-1:0] r;
        case (i)
            4'd0:    r = 32'h20000000;
            4'd1:    r = 32'h12E4051E;
            4'd2:    r = 32'h09FB385B;
            4'd3:    r = 32'h051111D4;
            4'd4:    r = 32'h028B0D43;
            4'd5:    r = 32'h0145D7E1;
            4'd6:    r = 32'h00A2F61E;
            4'd7:    r = 32'h00517C55;
            4'd8:    r = 32'h0028BE53;
            4'd9:    r = 32'h00145F2F;
            4'd10:   r = 32'h000A2F98;
            4'd11:   r = 32'h000517CC;
            4'd12:   r = 32'h00028BE6;
            4'd13:   r = 32'h000145F3;
            4'd14:   r = 32'h0000A2FA;
            default: r = 32'h0000517D;
        endcase
        return r;
    endfunction

    // log2 by leading one, 8 bit linear fraction, q8
    function automatic logic [LogW-1:0] log2_q8(input logic [63:0] v);
        logic [63:0] w;
        logic [5:0]  e;
        logic [63:0] t;
        w = (v == 64'd0) ? 64'd1 : v;
        e = 6'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (w[k])
            begin
                e = 6'(k);
            end
        end
        if (e >= 6'd8)
        begin
            t = w >> (e - 6'd8);
        end
        else
        begin
            t = w << (6'd8 - e);
        end
        return {2'b00, e, t[7:0]};
    endfunction

    // item carried from the front part to the back part
    typedef struct packed {
        logic                     first;
        logic                     last;
        logic signed [ProdW-1:0]  pr;
        logic signed [ProdW-1:0]  pi;
        logic [EnergyW-1:0]       energy;
        logic [LenW-1:0]          count;
        logic [NoiseW-1:0]        noise;
    } work_t;

endpackage

// File: rtl/core/edsa_if.sv
// ----------------------------------------------------------------------------
// edsa_in_if / edsa_out_if
// valid/ready channels of the echo doppler snr analyzer
// ----------------------------------------------------------------------------
interface edsa_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [30:0]        noise_level;
    logic               last_sample;
    modport source (output valid, sample_re, sample_im, noise_level, last_sample,
                    input ready);
    modport sink (input valid, sample_re, sample_im, noise_level, last_sample,
                  output ready);
endinterface

interface edsa_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] doppler_speed;
    logic               echo_done;
    logic signed [23:0] mean_speed;
    logic signed [15:0] snr_tenth_db;
    logic [16:0]        echo_length;
    modport source (output valid, doppler_speed, echo_done, mean_speed, snr_tenth_db,
                    echo_length, input ready);
    modport sink (input valid, doppler_speed, echo_done, mean_speed, snr_tenth_db,
                  echo_length, output ready);
endinterface

// File: rtl/core/edsa_front.sv
// ----------------------------------------------------------------------------
// edsa_front
// takes samples, forms the conjugate product, energy and echo position
// ----------------------------------------------------------------------------
module edsa_front (
    input  logic                    clk,
    input  logic                    rst_n,
    edsa_in_if.sink                 in_ch,
    output logic                    wvalid,
    input  logic                    wready,
    output edsa_pkg::work_t         wdata
);
    import edsa_pkg::*;

    localparam logic [LenW-1:0] MaxLen = LenW'(MaxEchoLen);

    logic signed [SampleW-1:0] prev_re_reg, prev_im_reg;
    logic [LenW-1:0]           count_reg;
    logic                      valid_reg;
    work_t                     data_reg;

    logic signed [31:0] rr, ii, ri, ir, er, ei;

    assign in_ch.ready = !valid_reg || wready;
    assign wvalid      = valid_reg;
    assign wdata       = data_reg;

    always_comb
    begin
        rr = in_ch.sample_re * prev_re_reg;
        ii = in_ch.sample_im * prev_im_reg;
        ir = in_ch.sample_im * prev_re_reg;
        ri = in_ch.sample_re * prev_im_reg;
        er = in_ch.sample_re * in_ch.sample_re;
        ei = in_ch.sample_im * in_ch.sample_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            count_reg   <= '0;
            prev_re_reg <= '0;
            prev_im_reg <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                valid_reg      <= 1'b1;
                data_reg.first <= (count_reg == '0);
                data_reg.last  <= in_ch.last_sample;
                data_reg.pr    <= ProdW'(rr) + ProdW'(ii);
                data_reg.pi    <= ProdW'(ir) - ProdW'(ri);
                data_reg.energy <= EnergyW'($unsigned(er)) + EnergyW'($unsigned(ei));
                data_reg.count <= (count_reg < MaxLen) ? count_reg + 1'b1 : count_reg;
                data_reg.noise <= in_ch.noise_level;
                if (in_ch.last_sample)
                begin
                    count_reg   <= '0;
                    prev_re_reg <= '0;
                    prev_im_reg <= '0;
                end
                else
                begin
                    count_reg   <= (count_reg < MaxLen) ? count_reg + 1'b1 : count_reg;
                    prev_re_reg <= in_ch.sample_re;
                    prev_im_reg <= in_ch.sample_im;
                end
            end
            else if (wready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/edsa_fifo.sv
// ----------------------------------------------------------------------------
// edsa_fifo
// two entry queue between front and back parts
// ----------------------------------------------------------------------------
module edsa_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wvalid,
    output logic            wready,
    input  edsa_pkg::work_t wdata,
    output logic            rvalid,
    input  logic            rready,
    output edsa_pkg::work_t rdata
);
    import edsa_pkg::*;

    work_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wready = (cnt_reg != 2'd2);
    assign rvalid = (cnt_reg != 2'd0);
    assign rdata  = mem_reg[rptr_reg];
    assign push   = wvalid && wready;
    assign pop    = rvalid && rready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/core/edsa_back.sv
// ----------------------------------------------------------------------------
// edsa_back
// cordic, speed scaling and sums per item; serial divide, snr on last item
// ----------------------------------------------------------------------------
module edsa_back #(
    parameter int unsigned PHASE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rvalid,
    output logic                             rready,
    input  edsa_pkg::work_t                  rdata,
    input  logic [edsa_pkg::GainW-1:0]       gain,
    input  logic [edsa_pkg::RatioW-1:0]      ratio,
    edsa_out_if.source                       out_ch
);
    import edsa_pkg::*;

    localparam int unsigned Shift = AngleW - PHASE_BITS;
    localparam int unsigned QW    = PHASE_BITS + 1;
    localparam int unsigned DW    = SumW + 2;
    localparam int unsigned CW    = ProdW + 3;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_SCALE, S_SUM, S_DIV, S_SNR, S_OUT
    } state_t;

    state_t                   state_reg;
    work_t                    item_reg;
    logic signed [CW-1:0]     x_reg, y_reg;
    logic [AngleW-1:0]        z_reg;
    logic [5:0]               it_reg;
    logic [QW+GainW-1:0]      prod_reg;
    logic                     neg_reg;
    logic signed [SpeedW-1:0] speed_reg;
    logic [EnergyW-1:0]       energy_reg;
    logic signed [SumW-1:0]   ssum_reg;
    logic [DW-1:0]            num_reg, rem_reg, quo_reg;
    logic signed [SpeedW-1:0] mean_reg;
    logic signed [SnrW-1:0]   snr_reg;
    logic signed [31:0]       lsc_reg;
    logic signed [LogW+2:0]   lval_reg;
    logic [31:0]              lq_reg;

    logic signed [CW-1:0]     dx, dy;
    logic [AngleW-1:0]        mag;
    logic [QW-1:0]            q;
    logic [QW+GainW-1:0]      sp;
    logic signed [SumW+1:0]   snext;
    logic [EnergyW:0]         esum;
    logic [DW-1:0]            remsh;
    logic [DW-1:0]            den2;
    logic signed [LogW+2:0]   lval;
    logic [31:0]              lmag;
    logic [18:0]              lhi;
    logic [37:0]              lprod;
    logic [31:0]              lq;

    always_comb
    begin
        dx    = y_reg >>> it_reg[3:0];
        dy    = x_reg >>> it_reg[3:0];
        mag   = z_reg[AngleW-1] ? (~z_reg + 1'b1) : z_reg;
        q     = QW'((33'(mag) + (33'd1 << (Shift - 1))) >> Shift);
        sp    = (prod_reg + ((QW+GainW)'(1) << (PHASE_BITS - 1))) >> PHASE_BITS;
        snext = (SumW+2)'(ssum_reg) + (SumW+2)'(speed_reg);
        esum  = {1'b0, energy_reg} + {1'b0, item_reg.energy};
        den2  = DW'({item_reg.count, 1'b0});
        remsh = {rem_reg[DW-2:0], num_reg[DW-1]};
        lval  = (LogW+3)'(log2_q8(64'(energy_reg))) - (LogW+3)'(log2_q8(64'(ratio)))
              + (LogW+3)'(2048) - (LogW+3)'(log2_q8(64'(item_reg.count)))
              - (LogW+3)'(log2_q8(64'(item_reg.noise)));
        lmag  = lsc_reg[31] ? 32'(-lsc_reg) : 32'(lsc_reg);
        // rounded divide by 256000: drop 2^11, then reciprocal of 125
        lhi   = 19'((lmag + 32'd128000) >> 11);
        lprod = 38'(lhi) * 38'(19'd268436);
        lq    = {19'd0, lprod[37:25]};
    end

    assign rready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_ch.valid <= 1'b0;
            energy_reg   <= '0;
            ssum_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (rvalid)
                    begin
                        item_reg <= rdata;
                        it_reg   <= '0;
                        if (rdata.pr < 0)
                        begin
                            x_reg <= -CW'(rdata.pr);
                            y_reg <= -CW'(rdata.pi);
                            z_reg <= 32'h80000000;
                        end
                        else
                        begin
                            x_reg <= CW'(rdata.pr);
                            y_reg <= CW'(rdata.pi);
                            z_reg <= '0;
                        end
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (item_reg.first || (item_reg.pr == 0 && item_reg.pi == 0))
                    begin
                        z_reg     <= '0;
                        state_reg <= S_SCALE;
                        prod_reg  <= '0;
                        neg_reg   <= 1'b0;
                    end
                    else if (it_reg == 6'(CordicN))
                    begin
                        neg_reg   <= z_reg[AngleW-1];
                        prod_reg  <= (QW+GainW)'(q) * (QW+GainW)'(gain);
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        if (y_reg >= 0)
                        begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            z_reg <= z_reg + cordic_turn(it_reg[3:0]);
                        end
                        else
                        begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            z_reg <= z_reg - cordic_turn(it_reg[3:0]);
                        end
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_SCALE:
                begin
                    if (sp > (QW+GainW)'(8388607))
                    begin
                        speed_reg <= neg_reg ? -24'sd8388608 : 24'sd8388607;
                    end
                    else
                    begin
                        speed_reg <= neg_reg ? -SpeedW'(sp) : SpeedW'(sp);
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    energy_reg <= esum[EnergyW] ? '1 : esum[EnergyW-1:0];
                    if (snext > (SumW+2)'((64'sd1 <<< 39) - 1))
                    begin
                        ssum_reg <= SumW'((64'sd1 <<< 39) - 1);
                    end
                    else if (snext < -(SumW+2)'(64'sd1 <<< 39))
                    begin
                        ssum_reg <= -SumW'(64'sd1 <<< 39);
                    end
                    else
                    begin
                        ssum_reg <= SumW'(snext);
                    end
                    if (item_reg.last)
                    begin
                        it_reg    <= '0;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                    num_reg <= '0;
                end
                S_DIV:
                begin
                    if (it_reg == 6'd0 && rem_reg == '0 && quo_reg == '0
                        && num_reg == '0)
                    begin
                        num_reg  <= (DW'(ssum_reg[SumW-1] ? $unsigned(-ssum_reg)
                                                          : $unsigned(ssum_reg)) << 1)
                                    + DW'(item_reg.count);
                        it_reg   <= 6'd1;
                        lval_reg <= lval;
                    end
                    else if (it_reg == 6'(DW + 1))
                    begin
                        if (quo_reg > DW'(8388607))
                        begin
                            mean_reg <= ssum_reg[SumW-1] ? -24'sd8388608 : 24'sd8388607;
                        end
                        else
                        begin
                            mean_reg <= ssum_reg[SumW-1] ? -SpeedW'(quo_reg)
                                                         : SpeedW'(quo_reg);
                        end
                        lq_reg    <= lq;
                        state_reg <= S_SNR;
                    end
                    else
                    begin
                        if (remsh >= den2)
                        begin
                            rem_reg <= remsh - den2;
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= remsh;
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        if (it_reg == 6'd1)
                        begin
                            lsc_reg <= 32'(lval_reg) * 32'sd30103;
                        end
                        num_reg <= num_reg << 1;
                        it_reg  <= it_reg + 1'b1;
                    end
                end
                S_SNR:
                begin
                    if (energy_reg == '0)
                    begin
                        snr_reg <= -16'sd32768;
                    end
                    else if (lq_reg > 32'd32767)
                    begin
                        snr_reg <= lsc_reg[31] ? -16'sd32768 : 16'sd32767;
                    end
                    else
                    begin
                        snr_reg <= lsc_reg[31] ? -SnrW'(lq_reg) : SnrW'(lq_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_ch.valid || out_ch.ready)
                    begin
                        out_ch.valid         <= 1'b1;
                        out_ch.doppler_speed <= speed_reg;
                        out_ch.echo_done     <= item_reg.last;
                        out_ch.mean_speed    <= item_reg.last ? mean_reg : '0;
                        out_ch.snr_tenth_db  <= item_reg.last ? snr_reg : '0;
                        out_ch.echo_length   <= item_reg.last ? item_reg.count : '0;
                        if (item_reg.last)
                        begin
                            energy_reg <= '0;
                            ssum_reg   <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_ch.valid && out_ch.ready && !(state_reg == S_OUT))
            begin
                out_ch.valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/echo_doppler_snr_analyzer_core.sv
// ----------------------------------------------------------------------------
// echo_doppler_snr_analyzer_core
// doppler speed and integrated snr of one radar echo
// ----------------------------------------------------------------------------
// the back part works on one sample at a time: shared cordic, speed scaling and sums;
// it takes no new sample until the last result is in the output register. the first
// sample of an echo skips the cordic; the last sample adds the 42 step serial divide
// and the snr step. a two entry queue lets the front keep taking samples while the
// back works. reset: asynchronous, clears echo state and loads register defaults
module echo_doppler_snr_analyzer_core #(
    parameter int unsigned PHASE_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    edsa_in_if.sink     in_ch,
    edsa_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import edsa_pkg::*;

    logic [GainW-1:0]  gain_reg;
    logic [RatioW-1:0] ratio_reg;
    logic              fw_valid, fw_ready, fr_valid, fr_ready;
    work_t             fw_data, fr_data;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GainReset;
            ratio_reg <= RatioReset;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                RegGain[0]:  gain_reg  <= pwdata[GainW-1:0];
                RegRatio[0]: ratio_reg <= pwdata[RatioW-1:0];
                default:     gain_reg  <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            RegGain[0]:  prdata = 32'(gain_reg);
            default:     prdata = 32'(ratio_reg);
        endcase
    end

    edsa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .wvalid(fw_valid), .wready(fw_ready), .wdata(fw_data)
    );

    edsa_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wvalid(fw_valid), .wready(fw_ready), .wdata(fw_data),
        .rvalid(fr_valid), .rready(fr_ready), .rdata(fr_data)
    );

    edsa_back #(.PHASE_BITS(PHASE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .rvalid(fr_valid), .rready(fr_ready), .rdata(fr_data),
        .gain(gain_reg), .ratio(ratio_reg), .out_ch(out_ch)
    );

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        fw_valid && !fw_ready |=> fw_valid)
        else $error("queue lost an item");
    a_no_done_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.echo_done |-> out_ch.echo_length == 17'd0)
        else $error("summary fields set on a non last result");

endmodule

// File: sim/echo_doppler_snr_analyzer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// echo_doppler_snr_analyzer_core_tb
// self-checking bench: echoes of complex samples go in, every doppler result
// is checked against an in-bench model of the cordic phase discriminator,
// the mean speed divide and the log based snr, under random idling and stalls
// ----------------------------------------------------------------------------
module echo_doppler_snr_analyzer_core_tb;
    import edsa_pkg::*;

    typedef struct {
        logic signed [SpeedW-1:0] speed;
        logic                     done;
        logic signed [SpeedW-1:0] mean;
        logic signed [SnrW-1:0]   snr;
        logic [LenW-1:0]          length;
    } echo_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    edsa_in_if  in_ch ();
    edsa_out_if out_ch ();

    echo_doppler_snr_analyzer_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    longint unsigned gain_reg;
    longint unsigned ratio_reg;
    longint          prev_re;
    longint          prev_im;
    longint unsigned energy_acc;
    longint          speed_acc;
    longint unsigned count_acc;

    echo_result_t pending_results[$];
    int           errors;
    int           samples_sent;
    int           echoes_sent;
    int           results_seen;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (2 * m + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint lg_q8(longint unsigned v);
        int              e;
        longint unsigned f;
        e = 0;
        if (v == 0)
        begin
            v = 1;
        end
        for (int k = 0; k < 64; k++)
        begin
            if (v[k])
            begin
                e = k;
            end
        end
        if (e >= 8)
        begin
            f = (v >> (e - 8)) & 64'hFF;
        end
        else
        begin
            f = (v << (8 - e)) & 64'hFF;
        end
        return longint'(e) * 256 + longint'(f);
    endfunction

    function automatic longint phase_step(longint x, longint y);
        logic [31:0] z;
        longint      dx;
        longint      dy;
        z = 32'd0;
        if (x == 0 && y == 0)
        begin
            return 0;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + cordic_turn(4'(i));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - cordic_turn(4'(i));
            end
        end
        return longint'($signed(z));
    endfunction

    function automatic echo_result_t predict_sample(longint re, longint im,
                                                    longint unsigned noise, bit last);
        echo_result_t    r;
        longint          speed;
        longint          z;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned sp;
        longint unsigned e;
        longint          snr;
        longint          l;
        speed = 0;
        e = longint'(re * re + im * im);
        if (count_acc != 0)
        begin
            z = phase_step(re * prev_re + im * prev_im, im * prev_re - re * prev_im);
            mag = (z < 0) ? -z : z;
            q = (mag + (64'd1 << 15)) >> 16;
            sp = (q * gain_reg + (64'd1 << 15)) >> 16;
            speed = (z < 0) ? -longint'(sp) : longint'(sp);
            speed = clip(speed, -8388608, 8388607);
        end
        if ((64'hFFFF_FFFF_FFFF - energy_acc) < e)
        begin
            energy_acc = 64'hFFFF_FFFF_FFFF;
        end
        else
        begin
            energy_acc = energy_acc + e;
        end
        speed_acc = clip(speed_acc + speed, -(64'sd1 << 39), (64'sd1 << 39) - 1);
        if (count_acc < 65536)
        begin
            count_acc++;
        end
        prev_re = re;
        prev_im = im;
        r.speed = speed[SpeedW-1:0];
        r.done = 1'b0;
        r.mean = '0;
        r.snr = '0;
        r.length = '0;
        if (last)
        begin
            if (energy_acc == 0)
            begin
                snr = -32768;
            end
            else
            begin
                l = lg_q8(energy_acc) - lg_q8(ratio_reg) + 2048 - lg_q8(count_acc)
                    - lg_q8(noise);
                snr = clip(div_round(l * 30103, 256000), -32768, 32767);
            end
            r.done = 1'b1;
            r.mean = clip(div_round(speed_acc, longint'(count_acc)),
                          -8388608, 8388607);
            r.snr = snr[SnrW-1:0];
            r.length = count_acc[LenW-1:0];
            prev_re = 0;
            prev_im = 0;
            energy_acc = 0;
            speed_acc = 0;
            count_acc = 0;
            echoes_sent++;
        end
        return r;
    endfunction

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic [30:0] noise, input bit last);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_re <= re;
        in_ch.sample_im <= im;
        in_ch.noise_level <= noise;
        in_ch.last_sample <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_sample(re, im, noise, last));
        samples_sent++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 1'b0} << 1;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == RegGain)
        begin
            gain_reg = value & 32'hFFFFFF;
        end
        else if (idx == RegRatio)
        begin
            ratio_reg = value & 32'hFFFF;
        end
    endtask

    function automatic logic [30:0] rand_noise();
        logic [30:0] n;
        case ($urandom_range(3))
            0: n = 31'($urandom_range(1, 255));
            1: n = 31'h7FFFFFFF;
            default: n = 31'($urandom);
        endcase
        return (n == 0) ? 31'd1 : n;
    endfunction

    function automatic logic [15:0] rand_part();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // rotating phasor with random step and noise, so doppler readings are coherent
    task automatic send_echo(input int len);
        real  ph;
        real  step;
        real  amp;
        logic [30:0] noise;
        ph = $urandom_range(0, 6283) / 1000.0;
        step = ($urandom_range(0, 6283) / 1000.0) - 3.1415;
        amp = $urandom_range(1, 32000);
        noise = rand_noise();
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_sample(rand_part(), rand_part(), noise, k == len - 1);
            end
            else
            begin
                send_sample(16'($rtoi(amp * $cos(ph))), 16'($rtoi(amp * $sin(ph))),
                            noise, k == len - 1);
            end
            ph = ph + step;
        end
    endtask

    task automatic test_directed();
        // single sample echo, first doppler forced to zero
        send_sample(16'sh7FFF, 16'sh7FFF, 31'd1, 1'b1);
        // zero energy echo
        send_sample(16'sh0000, 16'sh0000, 31'h7FFFFFFF, 1'b0);
        send_sample(16'sh0000, 16'sh0000, 31'h7FFFFFFF, 1'b1);
        // zero product after a zero sample, then half and quarter turn steps
        send_sample(16'sh0000, 16'sh0000, 31'd100, 1'b0);
        send_sample(16'sh4000, 16'sh0000, 31'd100, 1'b0);
        send_sample(-16'sh4000, 16'sh0000, 31'd100, 1'b0);
        send_sample(16'sh4000, 16'sh0000, 31'd100, 1'b0);
        send_sample(16'sh0000, 16'sh4000, 31'd100, 1'b0);
        send_sample(16'sh0000, -16'sh4000, 31'd100, 1'b1);
        // full scale extremes
        send_sample(16'sh8000, 16'sh8000, 31'h7FFFFFFF, 1'b0);
        send_sample(16'sh7FFF, 16'sh8000, 31'h2AAAAAAA, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 31'h55555555, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 31'd1, 1'b0);
        send_sample(16'sh0001, -16'sh0001, 31'd1, 1'b1);
        // tiny energy against big noise, strong negative snr
        send_sample(16'sh0001, 16'sh0000, 31'h7FFFFFFF, 1'b0);
        send_sample(16'sh0000, 16'sh0001, 31'h7FFFFFFF, 1'b1);
    endtask

    task automatic test_config_sweep();
        write_reg(RegGain, 32'hFFFFFF);
        write_reg(RegRatio, 32'd1);
        for (int k = 0; k < 4; k++) send_echo($urandom_range(1, 12));
        write_reg(RegGain, 32'd0);
        write_reg(RegRatio, 32'hFFFF);
        for (int k = 0; k < 4; k++) send_echo($urandom_range(1, 12));
        write_reg(RegGain, 32'($urandom));
        write_reg(RegRatio, 32'($urandom_range(1, 65535)));
        for (int k = 0; k < 4; k++) send_echo($urandom_range(1, 12));
        write_reg(RegGain, 32'(GainReset));
        write_reg(RegRatio, 32'(RatioReset));
    endtask

    task automatic test_idle_phases();
        int idle_sets[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{24, 24}};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_sets[p][0];
            recv_stall_pct = idle_sets[p][1];
            for (int k = 0; k < 9; k++) send_echo($urandom_range(1, 16));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_left = 600;
        for (int k = 0; k < 3; k++) send_echo($urandom_range(4, 10));
        // sender waits for all outstanding results
        drain();
        send_echo(6);
    endtask

    task automatic test_random_mix();
        while (samples_sent < 420)
        begin
            send_idle_pct = $urandom_range(0, 1) ? 30 : 0;
            recv_stall_pct = $urandom_range(0, 1) ? 30 : 0;
            send_echo($urandom_range(1, 20));
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        echo_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction speed %0d", $time,
                         out_ch.doppler_speed);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_ch.doppler_speed !== exp_r.speed || out_ch.echo_done !== exp_r.done
                    || out_ch.mean_speed !== exp_r.mean || out_ch.snr_tenth_db !== exp_r.snr
                    || out_ch.echo_length !== exp_r.length)
                begin
                    errors++;
                    $display("%0t: expected speed %0d done %0b mean %0d snr %0d len %0d",
                             $time, exp_r.speed, exp_r.done, exp_r.mean, exp_r.snr,
                             exp_r.length);
                    $display("%0t: actual   speed %0d done %0b mean %0d snr %0d len %0d",
                             $time, out_ch.doppler_speed, out_ch.echo_done,
                             out_ch.mean_speed, out_ch.snr_tenth_db, out_ch.echo_length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= 20000)
        begin
            $display("echo_doppler_snr_analyzer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_re = '0;
        in_ch.sample_im = '0;
        in_ch.noise_level = 31'd1;
        in_ch.last_sample = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        samples_sent = 0;
        echoes_sent = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        gain_reg = GainReset;
        ratio_reg = RatioReset;
        prev_re = 0;
        prev_im = 0;
        energy_acc = 0;
        speed_acc = 0;
        count_acc = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_idle_phases();
        test_backpressure();
        test_random_mix();

        stop_sending();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        $display("run covered %0d samples in %0d echoes, %0d results checked,",
                 samples_sent, echoes_sent, results_seen);
        $display("register extremes, four idle phases and a long output hold-off");
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("echo_doppler_snr_analyzer_core: match");
        end
        else
        begin
            $display("echo_doppler_snr_analyzer_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/edsa_pkg.sv
rtl/core/edsa_if.sv
rtl/core/edsa_front.sv
rtl/core/edsa_fifo.sv
rtl/core/edsa_back.sv
rtl/core/echo_doppler_snr_analyzer_core.sv
sim/echo_doppler_snr_analyzer_core_tb.sv
